@@ sv/apd_pkg.sv @@
package apd_pkg;

  // Input command codes
  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_FIRE   = 2'd1,
    CMD_LEVEL  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // Configuration register indexes
  localparam logic [2:0] REG_SAMPLE_INTERVAL = 3'd0;
  localparam logic [2:0] REG_IDLE_INTERVAL   = 3'd1;
  localparam logic [2:0] REG_MIN_PERIOD      = 3'd2;
  localparam logic [2:0] REG_MAX_PERIOD      = 3'd3;
  localparam logic [2:0] REG_INVERT_GATE     = 3'd4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 64;

  localparam logic [7:0] FULL_LEVEL = 8'hFF;
  localparam int POWER_SHIFT = 10;
  localparam int PULSE_SHIFT = 7;
  localparam int DIV_STEPS   = 32;
  localparam int DIV_CNT_W   = 6;

  // Datapath commands issued by the controller
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_SAMPLE,
    OP_FIRE_A,
    OP_FIRE_B,
    OP_SETLVL,
    OP_KN_RISE,
    OP_KN_CROSS,
    OP_DIV_STEP,
    OP_FIN_FIRE,
    OP_FIN_RISE,
    OP_FIN_CROSS,
    OP_OUT
  } dp_op_t;

  // Datapath status seen by the controller
  typedef struct packed {
    cmd_t cmd;
    logic fire_calc;
    logic need_div;
    logic div_last;
    logic out_free;
  } dp_stat_t;

  // Turn-on delay fraction of one line period, scaled by 1024
  localparam logic [10:0] POWER_TABLE [256] = '{
    11'd1024, 11'd983, 11'd966, 11'd953, 11'd942, 11'd932, 11'd924, 11'd915,
    11'd908, 11'd901, 11'd894, 11'd888, 11'd881, 11'd876, 11'd870, 11'd864,
    11'd859, 11'd854, 11'd849, 11'd844, 11'd839, 11'd834, 11'd830, 11'd825,
    11'd821, 11'd816, 11'd812, 11'd808, 11'd804, 11'd800, 11'd796, 11'd792,
    11'd788, 11'd784, 11'd780, 11'd777, 11'd773, 11'd769, 11'd766, 11'd762,
    11'd759, 11'd755, 11'd752, 11'd748, 11'd745, 11'd741, 11'd738, 11'd735,
    11'd731, 11'd728, 11'd725, 11'd722, 11'd719, 11'd715, 11'd712, 11'd709,
    11'd706, 11'd703, 11'd700, 11'd697, 11'd694, 11'd691, 11'd688, 11'd685,
    11'd682, 11'd679, 11'd676, 11'd673, 11'd670, 11'd667, 11'd664, 11'd662,
    11'd659, 11'd656, 11'd653, 11'd650, 11'd648, 11'd645, 11'd642, 11'd639,
    11'd636, 11'd634, 11'd631, 11'd628, 11'd625, 11'd623, 11'd620, 11'd617,
    11'd615, 11'd612, 11'd609, 11'd607, 11'd604, 11'd601, 11'd599, 11'd596,
    11'd593, 11'd591, 11'd588, 11'd585, 11'd583, 11'd580, 11'd578, 11'd575,
    11'd572, 11'd570, 11'd567, 11'd565, 11'd562, 11'd559, 11'd557, 11'd554,
    11'd552, 11'd549, 11'd547, 11'd544, 11'd541, 11'd539, 11'd536, 11'd534,
    11'd531, 11'd529, 11'd526, 11'd524, 11'd521, 11'd518, 11'd516, 11'd513,
    11'd511, 11'd508, 11'd506, 11'd503, 11'd500, 11'd498, 11'd495, 11'd493,
    11'd490, 11'd488, 11'd485, 11'd483, 11'd480, 11'd477, 11'd475, 11'd472,
    11'd470, 11'd467, 11'd465, 11'd462, 11'd459, 11'd457, 11'd454, 11'd452,
    11'd449, 11'd446, 11'd444, 11'd441, 11'd439, 11'd436, 11'd433, 11'd431,
    11'd428, 11'd425, 11'd423, 11'd420, 11'd417, 11'd415, 11'd412, 11'd409,
    11'd407, 11'd404, 11'd401, 11'd399, 11'd396, 11'd393, 11'd390, 11'd388,
    11'd385, 11'd382, 11'd379, 11'd376, 11'd374, 11'd371, 11'd368, 11'd365,
    11'd362, 11'd360, 11'd357, 11'd354, 11'd351, 11'd348, 11'd345, 11'd342,
    11'd339, 11'd336, 11'd333, 11'd330, 11'd327, 11'd324, 11'd321, 11'd318,
    11'd315, 11'd312, 11'd309, 11'd305, 11'd302, 11'd299, 11'd296, 11'd293,
    11'd289, 11'd286, 11'd283, 11'd279, 11'd276, 11'd272, 11'd269, 11'd265,
    11'd262, 11'd258, 11'd255, 11'd251, 11'd247, 11'd244, 11'd240, 11'd236,
    11'd232, 11'd228, 11'd224, 11'd220, 11'd216, 11'd212, 11'd208, 11'd203,
    11'd199, 11'd194, 11'd190, 11'd185, 11'd180, 11'd175, 11'd170, 11'd165,
    11'd160, 11'd154, 11'd148, 11'd143, 11'd136, 11'd130, 11'd123, 11'd116,
    11'd109, 11'd100, 11'd92, 11'd82, 11'd71, 11'd58, 11'd41, 11'd0
  };

  // a strictly after b in wrapping time
  function automatic logic is_after(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != 32'd0) && !d[31];
  endfunction

endpackage

@@ sv/ac_phase_angle_dimmer_core.sv @@
// Set-level and unused commands go straight to the output step; firing events and sensor
// samples may also run remainder passes in the shared divider (one pass per time advance,
// at most two per sample).
// Throughput: one item at a time; the next item is taken once the result is in the
// output register, which may still wait. Synchronous active-low reset restores the
// register defaults and clears all tracking state.
module ac_phase_angle_dimmer_core
  import apd_pkg::*;
#(
  parameter int DEBOUNCE_COUNT = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // now[31:0], sensor_level[32], new_level[40:33]
  input  logic [1:0]            in_tuser,   // cmd[1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // next_wake[31:0], gate_level[32],
                                            // line_period[56:33], crossing_known[57]
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_op_t   op;
  dp_stat_t stat;

  apd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .op        (op)
  );

  apd_dp #(
    .DEBOUNCE_COUNT (DEBOUNCE_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .stat      (stat),
    .in_cmd    (in_tuser),
    .in_data   (in_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

@@ sv/apd_ctrl.sv @@
module apd_ctrl
  import apd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  dp_stat_t stat,
  output dp_op_t   op
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FIRE_B,
    S_KN_RISE,
    S_KN_CROSS,
    S_DIV,
    S_FIN,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  dp_op_t fin_r, fin_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Sequence the datapath through one item
  always_comb begin
    state_nxt = state_r;
    fin_nxt   = fin_r;
    op        = OP_IDLE;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op        = OP_LOAD;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.cmd)
          CMD_SAMPLE: begin
            op        = OP_SAMPLE;
            state_nxt = S_KN_RISE;
          end
          CMD_FIRE: begin
            op        = OP_FIRE_A;
            state_nxt = stat.fire_calc ? S_FIRE_B : S_DONE;
          end
          CMD_LEVEL: begin
            op        = OP_SETLVL;
            state_nxt = S_DONE;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_FIRE_B: begin
        op = OP_FIRE_B;
        if (stat.need_div) begin
          fin_nxt   = OP_FIN_FIRE;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_KN_RISE: begin
        op = OP_KN_RISE;
        if (stat.need_div) begin
          fin_nxt   = OP_FIN_RISE;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_KN_CROSS;
        end
      end
      S_KN_CROSS: begin
        op = OP_KN_CROSS;
        if (stat.need_div) begin
          fin_nxt   = OP_FIN_CROSS;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        op = OP_DIV_STEP;
        if (stat.div_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        op        = fin_r;
        state_nxt = (fin_r == OP_FIN_RISE) ? S_KN_CROSS : S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          op        = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fin_r   <= OP_FIN_FIRE;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

@@ sv/apd_dp.sv @@
module apd_dp
  import apd_pkg::*;
#(
  parameter int DEBOUNCE_COUNT = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_op_t                op,
  output dp_stat_t              stat,
  input  logic [1:0]            in_cmd,
  input  logic [IN_DATA_W-1:0]  in_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data
);

  localparam int CNT_W = $clog2(DEBOUNCE_COUNT + 2);
  localparam logic [CNT_W-1:0] DC = CNT_W'(DEBOUNCE_COUNT);
  localparam logic [31:0] DC32 = 32'(DEBOUNCE_COUNT);

  // Captured item
  cmd_t        cmd_r;
  logic [31:0] now_r;
  logic        lvl_r;
  logic [7:0]  newlvl_r;

  // Configuration
  logic [15:0] si_r;
  logic [19:0] idle_r;
  logic [23:0] min_r, max_r;
  logic        inv_r;

  // Tracking state
  logic [CNT_W-1:0] hc_r, hc_nxt, lc_r, lc_nxt;
  logic [31:0] rc_r, rc_nxt, fc_r, fc_nxt, rise_r, rise_nxt, cross_r, cross_nxt;
  logic        rk_r, rk_nxt, cv_r, cv_nxt, pend_r, pend_nxt, gate_r, gate_nxt;
  logic [23:0] period_r, period_nxt;
  logic [31:0] fw_r, fw_nxt;
  logic [7:0]  power_r, power_nxt;

  // Work registers
  logic [31:0] wake_r, wake_nxt;
  logic [34:0] prod_r, prod_nxt;
  logic [31:0] m_r, m_nxt, dq_r, dq_nxt;
  logic [24:0] rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // Shared helper values
  logic [31:0] p32, p8, rem32, start, kn_t, kn_d, tgt_base, kn_new, skip, wake_s, cp;
  logic [24:0] rem_sh;
  logic        fire_calc, need_div;

  assign p32   = {8'd0, period_r};
  assign p8    = {5'd0, period_r, 3'd0};
  assign rem32 = {8'd0, rem_r[23:0]};
  assign start = cross_r + {7'd0, prod_r[34:POWER_SHIFT]} - p32;
  assign kn_t  = (op == OP_KN_CROSS) ? cross_r : rise_r;
  assign kn_d  = kn_t + p8 - wake_r;
  assign tgt_base = (op == OP_FIN_CROSS) ? cross_r : rise_r;
  assign kn_new = tgt_base + m_r + ((rem_r[23:0] != 24'd0) ? (p32 - rem32) : 32'd0);
  assign rem_sh = {rem_r[23:0], dq_r[31]};

  assign fire_calc = (power_r != 8'd0) && (period_r != 24'd0) && cv_r &&
                     (power_r != FULL_LEVEL) && !pend_r;

  // Decide whether the current step needs a remainder
  always_comb begin
    case (op)
      OP_FIRE_B:   need_div = !is_after(start, now_r);
      OP_KN_RISE:  need_div = (period_r != 24'd0) && rk_r && kn_d[31];
      OP_KN_CROSS: need_div = (period_r != 24'd0) && cv_r && kn_d[31];
      default:     need_div = 1'b0;
    endcase
  end

  assign stat.cmd       = cmd_r;
  assign stat.fire_calc = fire_calc;
  assign stat.need_div  = need_div;
  assign stat.div_last  = (cnt_r == DIV_CNT_W'(1));
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Next-state logic for every datapath command
  always_comb begin
    hc_nxt = hc_r;  lc_nxt = lc_r;  rc_nxt = rc_r;  fc_nxt = fc_r;
    rise_nxt = rise_r;  cross_nxt = cross_r;  rk_nxt = rk_r;  cv_nxt = cv_r;
    pend_nxt = pend_r;  gate_nxt = gate_r;  period_nxt = period_r;
    fw_nxt = fw_r;  power_nxt = power_r;
    wake_nxt = wake_r;  prod_nxt = prod_r;  m_nxt = m_r;  dq_nxt = dq_r;
    rem_nxt = rem_r;  cnt_nxt = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt = out_data_r;
    wake_s = now_r + {16'd0, si_r};
    cp = rc_r - rise_r;
    skip = rise_r + {8'd0, min_r} - 32'(DC32 * {16'd0, si_r});

    case (op)
      OP_SAMPLE: begin
        if (lvl_r) begin
          if (lc_r <= DC) lc_nxt = '0;
          if (hc_r < DC) begin
            if (hc_r == '0) rc_nxt = wake_s;
            hc_nxt = hc_r + CNT_W'(1);
          end else if (hc_r == DC) begin
            if (rk_r && (cp >= {8'd0, min_r}) && (cp <= {8'd0, max_r}))
              period_nxt = cp[23:0];
            hc_nxt   = DC + CNT_W'(1);
            rise_nxt = rc_r;
            rk_nxt   = 1'b1;
            lc_nxt   = '0;
          end
        end else begin
          if (hc_r <= DC) hc_nxt = '0;
          if (lc_r < DC) begin
            if (lc_r == '0) fc_nxt = wake_s;
            lc_nxt = lc_r + CNT_W'(1);
          end else if (lc_r == DC) begin
            if (rk_r) begin
              cross_nxt = rise_r + ((fc_r - rise_r) >> 1);
              cv_nxt    = 1'b1;
            end
            lc_nxt = DC + CNT_W'(1);
            hc_nxt = '0;
            // skip sampling through most of the next high phase
            if ((hc_r > DC) && is_after(skip, wake_s + {16'd0, si_r}))
              wake_s = skip;
          end
        end
        wake_nxt = wake_s;
      end
      OP_FIRE_A: begin
        if ((power_r == 8'd0) || (period_r == 24'd0) || !cv_r) begin
          gate_nxt = inv_r;
          pend_nxt = 1'b0;
          fw_nxt   = fw_r + {12'd0, idle_r};
        end else if (power_r == FULL_LEVEL) begin
          gate_nxt = !inv_r;
          pend_nxt = 1'b0;
          fw_nxt   = fw_r + {12'd0, idle_r};
        end else if (pend_r) begin
          gate_nxt = !inv_r;
          pend_nxt = 1'b0;
          fw_nxt   = fw_r + 32'(period_r >> PULSE_SHIFT);
        end else begin
          gate_nxt = inv_r;
          pend_nxt = 1'b1;
          prod_nxt = 35'(period_r) * 35'(POWER_TABLE[power_r]);
        end
      end
      OP_FIRE_B: begin
        if (need_div) begin
          m_nxt   = now_r - start;
          dq_nxt  = now_r - start;
          rem_nxt = '0;
          cnt_nxt = DIV_CNT_W'(DIV_STEPS);
        end else begin
          fw_nxt = start;
        end
      end
      OP_KN_RISE, OP_KN_CROSS: begin
        if (need_div) begin
          m_nxt   = 32'd0 - kn_d;
          dq_nxt  = 32'd0 - kn_d;
          rem_nxt = '0;
          cnt_nxt = DIV_CNT_W'(DIV_STEPS);
        end
      end
      OP_DIV_STEP: begin
        // one restoring remainder step
        rem_nxt = (rem_sh >= {1'b0, period_r}) ? (rem_sh - {1'b0, period_r}) : rem_sh;
        dq_nxt  = {dq_r[30:0], 1'b0};
        cnt_nxt = cnt_r - DIV_CNT_W'(1);
      end
      OP_FIN_FIRE:  fw_nxt    = now_r - rem32 + p32;
      OP_FIN_RISE:  rise_nxt  = kn_new;
      OP_FIN_CROSS: cross_nxt = kn_new;
      OP_SETLVL:    power_nxt = newlvl_r;
      OP_OUT: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = {6'd0, cv_r, period_r, gate_r,
                         (cmd_r == CMD_SAMPLE) ? wake_r : fw_r};
      end
      default: ;
    endcase
  end

  // Capture item and configuration
  always_ff @(posedge clk) begin
    if (op == OP_LOAD) begin
      cmd_r    <= cmd_t'(in_cmd);
      now_r    <= in_data[31:0];
      lvl_r    <= in_data[32];
      newlvl_r <= in_data[40:33];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      si_r   <= 16'd25;
      idle_r <= 20'd1000;
      min_r  <= 24'd7142;
      max_r  <= 24'd12500;
      inv_r  <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SAMPLE_INTERVAL: si_r   <= cfg_wdata[15:0];
        REG_IDLE_INTERVAL:   idle_r <= cfg_wdata[19:0];
        REG_MIN_PERIOD:      min_r  <= cfg_wdata;
        REG_MAX_PERIOD:      max_r  <= cfg_wdata;
        REG_INVERT_GATE:     inv_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r <= '0;  lc_r <= '0;  rc_r <= '0;  fc_r <= '0;
      rise_r <= '0;  cross_r <= '0;  rk_r <= 1'b0;  cv_r <= 1'b0;
      pend_r <= 1'b0;  gate_r <= 1'b0;  period_r <= '0;  fw_r <= '0;
      power_r <= '0;  out_valid_r <= 1'b0;
    end else begin
      hc_r <= hc_nxt;  lc_r <= lc_nxt;  rc_r <= rc_nxt;  fc_r <= fc_nxt;
      rise_r <= rise_nxt;  cross_r <= cross_nxt;  rk_r <= rk_nxt;  cv_r <= cv_nxt;
      pend_r <= pend_nxt;  gate_r <= gate_nxt;  period_r <= period_nxt;
      fw_r <= fw_nxt;  power_r <= power_nxt;  out_valid_r <= out_valid_nxt;
    end
  end

  // Work registers
  always_ff @(posedge clk) begin
    wake_r     <= wake_nxt;
    prod_r     <= prod_nxt;
    m_r        <= m_nxt;
    dq_r       <= dq_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

@@ tb/sv/tb_ac_phase_angle_dimmer_core.sv @@
module tb_ac_phase_angle_dimmer_core;
  import apd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned PHASE_ITEMS = 100;
  localparam int unsigned NUM_PHASES = 8;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic        crossing_known;
    logic [23:0] line_period;
    logic        gate_level;
    logic [31:0] next_wake;
  } dimmer_result_t;

  typedef struct {
    cmd_t        cmd;
    logic [31:0] now;
    logic        sensor_level;
    logic [7:0]  new_level;
  } dimmer_item_t;

  // Predicts the dimmer output for each accepted transfer and checks results in order
  class dimmer_tracker;
    logic [31:0] sample_iv, idle_iv, min_per, max_per;
    logic        invert;
    logic [31:0] hi_cnt, lo_cnt, rise_cand, fall_cand, rise_t, cross_t;
    logic        rise_ok, cross_ok, pulse_due;
    logic [31:0] period, fire_t;
    logic [7:0]  power;
    logic        gate;
    dimmer_result_t awaited[$];
    int unsigned    errors;

    function new();
      sample_iv = 25;
      idle_iv = 1000;
      min_per = 7142;
      max_per = 12500;
      invert = 1'b0;
      hi_cnt = 0;
      lo_cnt = 0;
      rise_cand = 0;
      fall_cand = 0;
      rise_t = 0;
      cross_t = 0;
      rise_ok = 1'b0;
      cross_ok = 1'b0;
      pulse_due = 1'b0;
      period = 0;
      fire_t = 0;
      power = 0;
      gate = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [23:0] val);
      case (idx)
        REG_SAMPLE_INTERVAL: sample_iv = {16'd0, val[15:0]};
        REG_IDLE_INTERVAL:   idle_iv = {12'd0, val[19:0]};
        REG_MIN_PERIOD:      min_per = {8'd0, val};
        REG_MAX_PERIOD:      max_per = {8'd0, val};
        REG_INVERT_GATE:     invert = val[0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function logic later_than(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return (d != 0) && !d[31];
    endfunction

    // step back one period, then forward by whole periods past now
    function logic [31:0] advance_past(logic [31:0] start, logic [31:0] now);
      logic [31:0] m, k;
      start = start - period;
      if (!later_than(start, now)) begin
        m = now - start;
        k = m / period + 1;
        start = start + k * period;
      end
      return start;
    endfunction

    // pull a stored time forward so that it stays within 8 periods of wake
    function logic [31:0] hold_near(logic [31:0] t, logic [31:0] wake);
      logic [31:0] d, m, k;
      d = t + 32'd8 * period - wake;
      if (d[31]) begin
        m = -d;
        k = m / period + ((m % period) != 0 ? 1 : 0);
        t = t + k * period;
      end
      return t;
    endfunction

    function logic [31:0] debounce(logic [31:0] now, logic lvl);
      logic [31:0] wake, cp, skip, prev_hi;
      wake = now + sample_iv;
      if (lvl) begin
        if (lo_cnt <= 5) lo_cnt = 0;
        if (hi_cnt < 5) begin
          if (hi_cnt == 0) rise_cand = wake;
          hi_cnt++;
        end else if (hi_cnt == 5) begin
          if (rise_ok) begin
            cp = rise_cand - rise_t;
            if (cp >= min_per && cp <= max_per) period = cp;
          end
          hi_cnt = 6;
          rise_t = rise_cand;
          rise_ok = 1'b1;
          lo_cnt = 0;
        end
      end else begin
        if (hi_cnt <= 5) hi_cnt = 0;
        if (lo_cnt < 5) begin
          if (lo_cnt == 0) fall_cand = wake;
          lo_cnt++;
        end else if (lo_cnt == 5) begin
          prev_hi = hi_cnt;
          if (rise_ok) begin
            cross_t = rise_t + ((fall_cand - rise_t) >> 1);
            cross_ok = 1'b1;
          end
          lo_cnt = 6;
          hi_cnt = 0;
          if (prev_hi > 5) begin
            skip = rise_t + min_per - 32'd5 * sample_iv;
            if (later_than(skip, wake + sample_iv)) wake = skip;
          end
        end
      end
      if (period != 0) begin
        if (rise_ok) rise_t = hold_near(rise_t, wake);
        if (cross_ok) cross_t = hold_near(cross_t, wake);
      end
      return wake;
    endfunction

    function void fire(logic [31:0] now);
      logic [63:0] prod;
      if (power == 0 || period == 0 || !cross_ok) begin
        gate = invert;
        pulse_due = 1'b0;
        fire_t = fire_t + idle_iv;
      end else if (power == FULL_LEVEL) begin
        gate = !invert;
        pulse_due = 1'b0;
        fire_t = fire_t + idle_iv;
      end else if (pulse_due) begin
        gate = !invert;
        pulse_due = 1'b0;
        fire_t = fire_t + (period >> 7);
      end else begin
        prod = 64'(period) * 64'(POWER_TABLE[power]);
        gate = invert;
        pulse_due = 1'b1;
        fire_t = advance_past(cross_t + prod[41:10], now);
      end
    endfunction

    function void take_item(dimmer_item_t it);
      dimmer_result_t r;
      r.next_wake = fire_t;
      case (it.cmd)
        CMD_SAMPLE: r.next_wake = debounce(it.now, it.sensor_level);
        CMD_FIRE: begin
          fire(it.now);
          r.next_wake = fire_t;
        end
        CMD_LEVEL: power = it.new_level;
        default: ;
      endcase
      r.gate_level = gate;
      r.line_period = period[23:0];
      r.crossing_known = cross_ok;
      awaited.push_back(r);
    endfunction

    function void match_result(logic [OUT_DATA_W-1:0] data);
      dimmer_result_t got, want;
      got = data[57:0];
      if (awaited.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.next_wake !== want.next_wake) begin
        $display("%0t next_wake: expected %h actual %h", $time, want.next_wake, got.next_wake);
        errors++;
      end
      if (got.gate_level !== want.gate_level) begin
        $display("%0t gate_level: expected %b actual %b", $time, want.gate_level,
                 got.gate_level);
        errors++;
      end
      if (got.line_period !== want.line_period) begin
        $display("%0t line_period: expected %h actual %h", $time, want.line_period,
                 got.line_period);
        errors++;
      end
      if (got.crossing_known !== want.crossing_known) begin
        $display("%0t crossing_known: expected %b actual %b", $time, want.crossing_known,
                 got.crossing_known);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  dimmer_tracker tracker = new();
  int unsigned   cycles = 0;
  logic          steady = 1'b0;

  // mains waveform seen by the sensor
  logic [31:0] clock_now;
  logic [31:0] wave_pos, wave_len, step_len;

  ac_phase_angle_dimmer_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // accept results with random stalls
  initial begin
    int unsigned gap;
    forever begin
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      tracker.match_result(out_tdata);
    end
  end

  task automatic send(cmd_t cmd, logic [31:0] now, logic lvl, logic [7:0] pwr);
    int unsigned gap;
    dimmer_item_t it;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {7'd0, pwr, lvl, now};
    do @(posedge clk); while (!in_tready);
    it.cmd = cmd;
    it.now = now;
    it.sensor_level = lvl;
    it.new_level = pwr;
    tracker.take_item(it);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    tracker.set_reg(idx, val);
  endtask

  // drain all results and let the block settle before touching registers
  task automatic settle();
    in_tvalid <= 1'b0;
    while (tracker.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(int unsigned phase);
    logic [23:0] s, idle, lo, hi;
    logic        inv;
    s = 24'($urandom_range(2, 12));
    wave_len = s * $urandom_range(12, 30);
    idle = 24'($urandom_range(1, 5000));
    lo = 24'(wave_len - 2 * s);
    hi = 24'(wave_len + 2 * s);
    inv = 1'($urandom_range(0, 1));
    case (phase)
      1: begin
        s = 24'd1;
        idle = 24'd1;
        wave_len = 16;
        lo = 24'd1;
        hi = 24'hFFFFFF;
        inv = 1'b1;
      end
      2: begin
        lo = 24'hFFFFFF;
        hi = 24'd1;
      end
      3: begin
        s = 24'hFFFF;
        wave_len = s * 14;
        idle = 24'hFFFFF;
        lo = 24'(wave_len - 2 * s);
        hi = 24'(wave_len + 2 * s);
        inv = 1'b0;
      end
      default: ;
    endcase
    step_len = {8'd0, s};
    wave_pos = 0;
    write_reg(REG_SAMPLE_INTERVAL, s);
    write_reg(REG_IDLE_INTERVAL, idle);
    write_reg(REG_MIN_PERIOD, lo);
    write_reg(REG_MAX_PERIOD, hi);
    write_reg(REG_INVERT_GATE, {23'd0, inv});
    write_reg(REG_UNUSED, 24'($urandom));
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_item();
    int unsigned pick;
    logic [7:0]  pwr;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      // next sample on the mains waveform, with the period drifting now and then
      clock_now = clock_now + step_len;
      wave_pos = wave_pos + step_len;
      if (wave_pos >= wave_len) begin
        wave_pos = wave_pos - wave_len;
        if ($urandom_range(0, 3) == 0)
          wave_len = $urandom_range(0, 1) ? wave_len + step_len : wave_len - step_len;
      end
      send(CMD_SAMPLE, clock_now, (wave_pos < wave_len / 2) ^ ($urandom_range(0, 49) == 0),
           8'($urandom));
    end else if (pick < 84) begin
      send(CMD_FIRE, clock_now + $urandom_range(0, 3 * step_len), 1'($urandom),
           8'($urandom));
    end else if (pick < 93) begin
      case ($urandom_range(0, 5))
        0: pwr = 8'd0;
        1: pwr = FULL_LEVEL;
        2: pwr = 8'd254;
        3: pwr = 8'd1;
        default: pwr = 8'($urandom);
      endcase
      send(CMD_LEVEL, $urandom, 1'($urandom), pwr);
    end else if (pick < 96) begin
      send(CMD_NONE, $urandom, 1'($urandom), 8'($urandom));
    end else begin
      // noise: sample at an arbitrary time and level
      send($urandom_range(0, 1) ? CMD_SAMPLE : CMD_FIRE, $urandom, 1'($urandom),
           8'($urandom));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset defaults, field extremes, every command
    send(CMD_NONE, 32'hFFFFFFFF, 1'b1, 8'hFF);
    send(CMD_FIRE, 32'd0, 1'b0, 8'd0);
    send(CMD_LEVEL, 32'd0, 1'b0, FULL_LEVEL);
    send(CMD_FIRE, 32'hFFFFFFFF, 1'b0, 8'd0);
    send(CMD_LEVEL, 32'd0, 1'b0, 8'd128);
    send(CMD_FIRE, 32'h80000000, 1'b1, 8'd0);
    for (int i = 0; i < 6; i++) send(CMD_SAMPLE, 32'hFFFFFFF0 + i, 1'b1, 8'd0);
    for (int i = 0; i < 6; i++) send(CMD_SAMPLE, 32'h00000010 + i, 1'b0, 8'hFF);
    send(CMD_SAMPLE, 32'hFFFFFFFF, 1'b1, 8'd0);
    send(CMD_SAMPLE, 32'd0, 1'b0, 8'd0);
    send(CMD_LEVEL, 32'hFFFFFFFF, 1'b1, 8'd0);
    send(CMD_FIRE, 32'd0, 1'b0, 8'd0);
    settle();

    // random phases, each with its own register setting
    clock_now = $urandom;
    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      configure(ph);
      steady = (ph == 5);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) random_item();
      settle();
    end

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
